### hdl/mpfb_pkg.sv
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared constants, codes, types and helpers of the page framebuffer raster
// engine.
// ----------------------------------------------------------------------------
package mpfb_pkg;

    localparam int DISPLAY_WIDTH = 128;
    localparam int PAGE_COUNT    = 4;
    localparam int ROW_COUNT     = 8 * PAGE_COUNT;
    localparam int STORE_DEPTH   = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    // fixed field widths of the request and response ports
    localparam int REQ_W  = 3;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int PAGE_W = 2;
    localparam int BYTE_W = 8;
    localparam int BMPW_W = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_FILL   = 3'd0,
        REQ_PIXEL  = 3'd1,
        REQ_BITMAP = 3'd2,
        REQ_LINE   = 3'd3,
        REQ_READ   = 3'd4
    } mpfb_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_LINE_RD,
        ST_LINE_WR,
        ST_READ,
        ST_READ_DATA,
        ST_DONE
    } mpfb_state_t;

    // up to two byte updates for one bitmap byte (it may straddle two pages)
    typedef struct packed {
        logic              ok0;
        logic [ADDR_W-1:0] addr0;
        logic [BYTE_W-1:0] mask0;
        logic [BYTE_W-1:0] data0;
        logic              ok1;
        logic [ADDR_W-1:0] addr1;
        logic [BYTE_W-1:0] mask1;
        logic [BYTE_W-1:0] data1;
    } bmp_plan_t;

    typedef struct packed {
        logic             active;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } line_pt_t;

    function automatic logic [ADDR_W-1:0] frame_addr(input logic [7:0] pg,
                                                     input logic [8:0] col);
        int sum;
        sum = int'(pg) * DISPLAY_WIDTH + int'(col);
        return ADDR_W'(sum);
    endfunction

endpackage

### hdl/mpfb_frame_mem.sv
// ----------------------------------------------------------------------------
// mpfb_frame_mem
// Single-port frame byte store, synchronous write, registered read.
// ----------------------------------------------------------------------------
module mpfb_frame_mem (
    input  logic                        clk,
    input  logic                        we,
    input  logic [mpfb_pkg::ADDR_W-1:0] addr,
    input  logic [mpfb_pkg::BYTE_W-1:0] wdata,
    output logic [mpfb_pkg::BYTE_W-1:0] rdata
);
    import mpfb_pkg::*;

    logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[addr] <= wdata;
        end
        rd_data_reg <= store_mem[addr];
    end

    assign rdata = rd_data_reg;

endmodule

### hdl/mpfb_bitmap_unit.sv
// ----------------------------------------------------------------------------
// mpfb_bitmap_unit
// Bitmap cursor and the byte update plan for one vertical bitmap byte.
// ----------------------------------------------------------------------------
module mpfb_bitmap_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [mpfb_pkg::COL_W-1:0]  x_start,
    input  logic [mpfb_pkg::ROW_W-1:0]  y_start,
    input  logic                        pixel_value,
    input  logic [mpfb_pkg::BYTE_W-1:0] column_bits,
    input  logic [mpfb_pkg::BMPW_W-1:0] bitmap_width,
    input  logic                        last_byte,
    output mpfb_pkg::bmp_plan_t         plan
);
    import mpfb_pkg::*;

    logic [6:0]        col_reg, col_next;
    logic [5:0]        row_reg, row_next;
    logic [7:0]        cx;
    logic [6:0]        r0;
    logic [3:0]        pg0;
    logic [4:0]        pg1;
    logic [2:0]        sh0;
    logic [3:0]        sh1;
    logic [BYTE_W-1:0] val;
    logic              col_ok;
    logic [7:0]        col_inc;

    assign cx     = {1'b0, x_start} + {1'b0, col_reg};
    assign r0     = {2'b00, y_start} + {1'b0, row_reg};
    assign pg0    = r0[6:3];
    assign pg1    = {1'b0, pg0} + 5'd1;
    assign sh0    = r0[2:0];
    assign sh1    = 4'd8 - {1'b0, sh0};
    assign val    = pixel_value ? column_bits : ~column_bits;
    assign col_ok = ({1'b0, cx} < 9'(DISPLAY_WIDTH));

    always_comb
    begin
        plan.ok0   = col_ok && (pg0 < 4'(PAGE_COUNT));
        plan.addr0 = frame_addr({4'b0000, pg0}, {1'b0, cx});
        plan.mask0 = 8'hff << sh0;
        plan.data0 = val << sh0;
        // upper part spills into the next page only for an unaligned row
        plan.ok1   = col_ok && (sh0 != 3'd0) && (pg1 < 5'(PAGE_COUNT));
        plan.addr1 = frame_addr({3'b000, pg1}, {1'b0, cx});
        plan.mask1 = 8'hff >> sh1;
        plan.data1 = val >> sh1;
    end

    assign col_inc = {1'b0, col_reg} + 8'd1;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (adv)
        begin
            if (col_inc == bitmap_width)
            begin
                col_next = 7'd0;
                row_next = row_reg + 6'd8;
            end
            else
            begin
                col_next = col_inc[6:0];
            end
            if (last_byte)
            begin
                col_next = 7'd0;
                row_next = 6'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= 7'd0;
            row_reg <= 6'd0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### hdl/mpfb_line_gen.sv
// ----------------------------------------------------------------------------
// mpfb_line_gen
// DDA point stepper with exact rational rounding (ties upward), end point
// left out. One point per step.
// ----------------------------------------------------------------------------
module mpfb_line_gen (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       step,
    input  logic [mpfb_pkg::COL_W-1:0] x_start,
    input  logic [mpfb_pkg::ROW_W-1:0] y_start,
    input  logic [mpfb_pkg::COL_W-1:0] x_end,
    input  logic [mpfb_pkg::ROW_W-1:0] y_end,
    output mpfb_pkg::line_pt_t         pt
);
    import mpfb_pkg::*;

    logic signed [7:0]  dx, dy_w;
    logic signed [5:0]  dy;
    logic [6:0]         ax, ay, n;

    logic [COL_W-1:0]   x_reg, x_next;
    logic [ROW_W-1:0]   y_reg, y_next;
    logic [7:0]         rx_reg, rx_next, ry_reg, ry_next;
    logic signed [8:0]  dx2_reg, dx2_next, dy2_reg, dy2_next;
    logic [7:0]         two_n_reg, two_n_next;
    logic [6:0]         cnt_reg, cnt_next;

    logic signed [10:0] x_sum, x_dn, y_sum, y_dn;

    assign dx   = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
    assign dy   = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
    assign dy_w = 8'(dy);
    assign ax   = dx[7] ? 7'(-dx) : 7'(dx);
    assign ay   = dy[5] ? {2'b00, 5'(-dy)} : {2'b00, 5'(dy)};
    assign n    = (ax >= ay) ? ax : ay;

    // remainder update: at most one wrap per step since |d| <= n
    assign x_sum = $signed({3'b000, rx_reg}) + 11'(dx2_reg);
    assign x_dn  = x_sum - $signed({3'b000, two_n_reg});
    assign y_sum = $signed({3'b000, ry_reg}) + 11'(dy2_reg);
    assign y_dn  = y_sum - $signed({3'b000, two_n_reg});

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        dx2_next   = dx2_reg;
        dy2_next   = dy2_reg;
        two_n_next = two_n_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            x_next     = x_start;
            y_next     = y_start;
            rx_next    = {1'b0, n};
            ry_next    = {1'b0, n};
            dx2_next   = {dx, 1'b0};
            dy2_next   = {dy_w, 1'b0};
            two_n_next = {n, 1'b0};
            cnt_next   = n;
        end
        else if (step && (cnt_reg != 7'd0))
        begin
            cnt_next = cnt_reg - 7'd1;
            if (!x_dn[10])
            begin
                rx_next = x_dn[7:0];
                x_next  = x_reg + 7'd1;
            end
            else if (x_sum[10])
            begin
                rx_next = 8'(x_sum + $signed({3'b000, two_n_reg}));
                x_next  = x_reg - 7'd1;
            end
            else
            begin
                rx_next = x_sum[7:0];
            end
            if (!y_dn[10])
            begin
                ry_next = y_dn[7:0];
                y_next  = y_reg + 5'd1;
            end
            else if (y_sum[10])
            begin
                ry_next = 8'(y_sum + $signed({3'b000, two_n_reg}));
                y_next  = y_reg - 5'd1;
            end
            else
            begin
                ry_next = y_sum[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 7'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        dx2_reg   <= dx2_next;
        dy2_reg   <= dy2_next;
        two_n_reg <= two_n_next;
    end

    always_comb
    begin
        pt.active = (cnt_reg != 7'd0);
        pt.col    = x_reg;
        pt.row    = y_reg;
    end

endmodule

### hdl/mono_page_framebuffer_raster_top.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_raster_top
// Raster engine over a page-organized monochrome frame store: fill, pixel,
// bitmap byte, DDA line and byte read on one RAM (pixel/bitmap/line by RMW).
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   request | req_valid/req_ready  | req_type x_start y_start x_end y_end
//           |                      | pixel_value column_bits bitmap_width
//           |                      | last_byte page
//   result  | rsp_valid/rsp_ready  | read_data data_valid
//
// Pixel and read touch one byte; a bitmap byte touches one, two when it straddles
// two pages, none when fully off screen; a line touches one byte per drawn point;
// fill writes all STORE_DEPTH bytes. All are bound by the single RAM port.
// After reset the store is cleared with req_ready low. A held result does not
// block accepting the next request; that request waits at completion until the
// result register frees.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_raster_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [mpfb_pkg::REQ_W-1:0]  req_type,
    input  logic [mpfb_pkg::COL_W-1:0]  x_start,
    input  logic [mpfb_pkg::ROW_W-1:0]  y_start,
    input  logic [mpfb_pkg::COL_W-1:0]  x_end,
    input  logic [mpfb_pkg::ROW_W-1:0]  y_end,
    input  logic                        pixel_value,
    input  logic [mpfb_pkg::BYTE_W-1:0] column_bits,
    input  logic [mpfb_pkg::BMPW_W-1:0] bitmap_width,
    input  logic                        last_byte,
    input  logic [mpfb_pkg::PAGE_W-1:0] page,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [mpfb_pkg::BYTE_W-1:0] read_data,
    output logic                        data_valid
);
    import mpfb_pkg::*;

    mpfb_state_t       state_reg, state_next;

    logic [ADDR_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [BYTE_W-1:0] fill_byte_reg, fill_byte_next;
    logic              pend1_reg, pend1_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic [ADDR_W-1:0] addr_reg, addr_next, addr1_reg, addr1_next;
    logic [BYTE_W-1:0] mask_reg, mask_next, mask1_reg, mask1_next;
    logic [BYTE_W-1:0] data_reg, data_next, data1_reg, data1_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [BYTE_W-1:0] res_data_reg, res_data_next;
    logic              res_dv_reg, res_dv_next;
    logic [BYTE_W-1:0] read_data_reg, read_data_next;
    logic              data_valid_reg, data_valid_next;

    logic              accept;
    logic              sweep_last;
    logic              rsp_free;
    logic              pix_ok, rd_ok, line_ok;
    logic [ADDR_W-1:0] pix_addr, rd_addr, line_addr;
    logic [BYTE_W-1:0] pix_mask, line_mask;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_wdata, mem_rdata, merged;

    logic              bmp_adv, line_load, line_step;
    bmp_plan_t         plan;
    line_pt_t          line_pt;

    mpfb_frame_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    mpfb_bitmap_unit u_bmp (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (bmp_adv),
        .x_start      (x_start),
        .y_start      (y_start),
        .pixel_value  (pixel_value),
        .column_bits  (column_bits),
        .bitmap_width (bitmap_width),
        .last_byte    (last_byte),
        .plan         (plan)
    );

    mpfb_line_gen u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (line_load),
        .step    (line_step),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .pt      (line_pt)
    );

    assign accept     = req_valid && req_ready;
    assign sweep_last = (sweep_cnt_reg == ADDR_W'(STORE_DEPTH - 1));
    assign rsp_free   = !rsp_valid_reg || rsp_ready;
    assign bmp_adv    = accept && (req_type == REQ_BITMAP);
    assign line_load  = accept && (req_type == REQ_LINE);

    assign pix_ok   = ({2'b00, x_start} < 9'(DISPLAY_WIDTH)) &&
                      ({2'b00, y_start} < 7'(ROW_COUNT));
    assign pix_addr = frame_addr(8'(y_start[ROW_W-1:3]), {2'b00, x_start});
    assign pix_mask = 8'h01 << y_start[2:0];

    assign rd_ok    = ({2'b00, x_start} < 9'(DISPLAY_WIDTH)) &&
                      ({2'b00, page} < 4'(PAGE_COUNT));
    assign rd_addr  = frame_addr(8'(page), {2'b00, x_start});

    assign line_ok   = ({2'b00, line_pt.col} < 9'(DISPLAY_WIDTH)) &&
                       ({2'b00, line_pt.row} < 7'(ROW_COUNT));
    assign line_addr = frame_addr(8'(line_pt.row[ROW_W-1:3]), {2'b00, line_pt.col});
    assign line_mask = 8'h01 << line_pt.row[2:0];

    assign merged = (mem_rdata & ~mask_reg) | (data_reg & mask_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                if (sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_type)
                        REQ_FILL:   state_next = ST_FILL;
                        REQ_PIXEL:  state_next = pix_ok ? ST_RMW_RD : ST_DONE;
                        REQ_BITMAP: state_next = (plan.ok0 || plan.ok1) ? ST_RMW_RD
                                                                         : ST_DONE;
                        REQ_LINE:   state_next = ST_LINE_RD;
                        REQ_READ:   state_next = ST_READ;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_RMW_RD:    state_next = ST_RMW_WR;
            ST_RMW_WR:    state_next = pend1_reg ? ST_RMW_RD : ST_DONE;
            ST_LINE_RD:
            begin
                if (!line_pt.active)
                begin
                    state_next = ST_DONE;
                end
                else if (line_ok)
                begin
                    state_next = ST_LINE_WR;
                end
            end
            ST_LINE_WR:   state_next = ST_LINE_RD;
            ST_READ:      state_next = ST_READ_DATA;
            ST_READ_DATA: state_next = ST_DONE;
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // state outputs: RAM port and line stepping
    always_comb
    begin
        req_ready = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = addr_reg;
        mem_wdata = merged;
        line_step = 1'b0;
        case (state_reg)
            ST_CLEAR, ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_addr  = sweep_cnt_reg;
                mem_wdata = fill_byte_reg;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_RMW_WR, ST_LINE_WR:
            begin
                mem_we    = 1'b1;
                line_step = (state_reg == ST_LINE_WR);
            end
            ST_LINE_RD:
            begin
                mem_addr  = line_addr;
                line_step = line_pt.active && !line_ok;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        sweep_cnt_next  = sweep_cnt_reg;
        fill_byte_next  = fill_byte_reg;
        pend1_next      = pend1_reg;
        rsp_valid_next  = rsp_valid_reg;
        addr_next       = addr_reg;
        mask_next       = mask_reg;
        data_next       = data_reg;
        addr1_next      = addr1_reg;
        mask1_next      = mask1_reg;
        data1_next      = data1_reg;
        rd_ok_next      = rd_ok_reg;
        res_data_next   = res_data_reg;
        res_dv_next     = res_dv_reg;
        read_data_next  = read_data_reg;
        data_valid_next = data_valid_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR, ST_FILL:
            begin
                sweep_cnt_next = sweep_last ? '0 : sweep_cnt_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_dv_next    = (req_type == REQ_READ);
                    res_data_next  = '0;
                    fill_byte_next = {BYTE_W{pixel_value}};
                    addr1_next     = plan.addr1;
                    mask1_next     = plan.mask1;
                    data1_next     = plan.data1;
                    rd_ok_next     = rd_ok;
                    pend1_next     = 1'b0;
                    case (req_type)
                        REQ_PIXEL:
                        begin
                            addr_next = pix_addr;
                            mask_next = pix_mask;
                            data_next = pixel_value ? pix_mask : '0;
                        end
                        REQ_BITMAP:
                        begin
                            if (plan.ok0)
                            begin
                                addr_next  = plan.addr0;
                                mask_next  = plan.mask0;
                                data_next  = plan.data0;
                                pend1_next = plan.ok1;
                            end
                            else
                            begin
                                addr_next = plan.addr1;
                                mask_next = plan.mask1;
                                data_next = plan.data1;
                            end
                        end
                        REQ_READ:
                        begin
                            addr_next = rd_addr;
                        end
                        default:
                        begin
                            addr_next = addr_reg;
                        end
                    endcase
                end
            end
            ST_RMW_WR:
            begin
                if (pend1_reg)
                begin
                    addr_next  = addr1_reg;
                    mask_next  = mask1_reg;
                    data_next  = data1_reg;
                    pend1_next = 1'b0;
                end
            end
            ST_LINE_RD:
            begin
                addr_next = line_addr;
                mask_next = line_mask;
                data_next = line_mask;
            end
            ST_READ_DATA:
            begin
                res_data_next = rd_ok_reg ? mem_rdata : '0;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    read_data_next  = res_data_reg;
                    data_valid_next = res_dv_reg;
                end
            end
            default:
            begin
                pend1_next = pend1_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_cnt_reg <= '0;
            fill_byte_reg <= '0;
            pend1_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            fill_byte_reg <= fill_byte_next;
            pend1_reg     <= pend1_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        mask_reg       <= mask_next;
        data_reg       <= data_next;
        addr1_reg      <= addr1_next;
        mask1_reg      <= mask1_next;
        data1_reg      <= data1_next;
        rd_ok_reg      <= rd_ok_next;
        res_data_reg   <= res_data_next;
        res_dv_reg     <= res_dv_next;
        read_data_reg  <= read_data_next;
        data_valid_reg <= data_valid_next;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_data  = read_data_reg;
    assign data_valid = data_valid_reg;

    // every accepted transaction takes the sequencer out of idle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // the line stepper only holds points while the sequencer walks a line
    a_line_owned: assert property (@(posedge clk) disable iff (!rst_n)
        line_pt.active |-> (state_reg == ST_LINE_RD || state_reg == ST_LINE_WR))
        else $error("line points pending outside of line drawing");

    // a second page update is only pending inside a read-modify-write
    a_pend_in_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        pend1_reg |-> (state_reg == ST_RMW_RD || state_reg == ST_RMW_WR))
        else $error("second page update pending outside read-modify-write");

endmodule
